FILE: rtl/phic_pkg.sv
`default_nettype none

package phic_pkg;

	localparam int unsigned WORD_W  = 16;
	localparam int unsigned ADDR_W  = 32;
	localparam int unsigned PROTO_W = 8;
	localparam int unsigned SUM_W   = 32;
	// widest item contribution: six 16-bit words plus one byte
	localparam int unsigned TERM_W  = 19;

	localparam logic [WORD_W-1:0] ODD_MASK = 16'hFF00;

	typedef logic [TERM_W-1:0] term_t;

	// step control handed to the accumulator
	typedef struct packed {
		logic fire;
		logic last;
	} step_t;

endpackage

`default_nettype wire

FILE: rtl/pseudo_header_internet_checksum.sv
// Internet checksum (RFC 1071) over a segment of 16-bit words in network
// order, with an optional TCP/UDP pseudo header. Feed one word per item on
// the slave stream; tlast marks the final word of a segment, and only on
// that item do tuser (odd tail, pseudo mode) and the address, length and
// protocol fields matter. In pseudo mode the final item also adds both
// address halves, the length and the protocol byte; an odd tail keeps only
// the high byte (low byte padded with zero). In plain mode an odd final
// word is dropped. One result item, the one's complement of the twice
// folded sum, leaves on the master stream per segment, and the running sum
// clears. The block takes one item every cycle: an input register holds the
// item's pre-added contribution, one 32-bit add updates the running sum, a
// fold of that sum feeds a result register on the master side that lets
// words keep flowing while a checksum waits. A final word passes through the
// input register and then the result register. The input stalls only when a
// final word meets a result that has not yet been taken. The sum can wrap
// modulo 2^32 for segments beyond 65531 words.
`default_nettype none

module pseudo_header_internet_checksum (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// slave stream
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// s_tdata fields, low bit up: data_word[15:0], src_address[47:16],
	// dst_address[79:48], seg_length[95:80], protocol[103:96]
	input  wire logic [103:0] s_tdata,
	input  wire logic         s_tlast,   // is_last
	// s_tuser fields, low bit up: odd_tail[0], use_pseudo[1]
	input  wire logic [1:0]   s_tuser,
	// master stream
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// m_tdata fields, low bit up: checksum_value[15:0]
	output logic [15:0]       m_tdata
);

	phic_pkg::term_t term_in;
	phic_pkg::term_t term_s1;
	logic            valid_s1;
	logic            last_s1;
	logic            in_fire;
	logic            out_free;
	logic            consume;
	phic_pkg::step_t step;

	// contribution of the incoming item, computed ahead of the input register
	phic_term u_term (
		.data_word   (s_tdata[15:0]),
		.is_last     (s_tlast),
		.odd_tail    (s_tuser[0]),
		.use_pseudo  (s_tuser[1]),
		.src_address (s_tdata[47:16]),
		.dst_address (s_tdata[79:48]),
		.seg_length  (s_tdata[95:80]),
		.protocol    (s_tdata[103:96]),
		.term        (term_in)
	);

	// result register is free when empty or being drained this cycle
	assign out_free = !m_tvalid || m_tready;
	// a final word may advance only into a free result register
	assign consume  = valid_s1 && (!last_s1 || out_free);
	assign s_tready = !valid_s1 || consume;
	assign in_fire  = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	// hold the payload until the item is consumed
	always_ff @(posedge clk) begin
		if (in_fire) begin
			term_s1 <= term_in;
			last_s1 <= s_tlast;
		end
	end

	assign step.fire = consume;
	assign step.last = last_s1;

	phic_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.term      (term_s1),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_data  (m_tdata)
	);

`ifndef SYNTH
	// a final word leaving the input register always produces a result
	a_last_makes_result: assert property (@(posedge clk) disable iff (!arst_n)
		(consume && last_s1) |=> m_tvalid)
		else $error("final item consumed without a result");

	// a new result appears only after a final word was consumed
	a_result_has_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(consume && last_s1))
		else $error("result appeared without a final item");

	// a blocked final word stalls the input
	a_blocked_last_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && last_s1 && m_tvalid && !m_tready) |-> !s_tready)
		else $error("input accepted while a final item is blocked");
`endif

endmodule

`default_nettype wire

FILE: rtl/phic_term.sv
`default_nettype none

// Contribution of one item to the running sum.
module phic_term (
	input  wire logic [phic_pkg::WORD_W-1:0]  data_word,
	input  wire logic                         is_last,
	input  wire logic                         odd_tail,
	input  wire logic                         use_pseudo,
	input  wire logic [phic_pkg::ADDR_W-1:0]  src_address,
	input  wire logic [phic_pkg::ADDR_W-1:0]  dst_address,
	input  wire logic [phic_pkg::WORD_W-1:0]  seg_length,
	input  wire logic [phic_pkg::PROTO_W-1:0] protocol,
	output phic_pkg::term_t                   term
);

	logic [phic_pkg::WORD_W-1:0] word_sel;
	phic_pkg::term_t             hdr_sum;

	always_comb begin
		word_sel = data_word;
		if (is_last && odd_tail) begin
			// pseudo mode pads the missing byte with zero, plain mode drops the word
			word_sel = use_pseudo ? (data_word & phic_pkg::ODD_MASK) : '0;
		end
	end

	assign hdr_sum = phic_pkg::term_t'(src_address[31:16]) + phic_pkg::term_t'(src_address[15:0])
		+ phic_pkg::term_t'(dst_address[31:16]) + phic_pkg::term_t'(dst_address[15:0])
		+ phic_pkg::term_t'(seg_length) + phic_pkg::term_t'(protocol);

	assign term = phic_pkg::term_t'(word_sel)
		+ ((is_last && use_pseudo) ? hdr_sum : phic_pkg::term_t'(0));

endmodule

`default_nettype wire

FILE: rtl/phic_accum.sv
`default_nettype none

// Running sum, end-of-segment fold and result register.
module phic_accum (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire phic_pkg::step_t             step,
	input  wire phic_pkg::term_t             term,
	input  wire logic                        out_ready,
	output logic                             out_valid,
	output logic [phic_pkg::WORD_W-1:0]      out_data
);

	logic [phic_pkg::SUM_W-1:0]  running_sum_q;
	logic [phic_pkg::SUM_W-1:0]  sum_next;
	logic [phic_pkg::WORD_W:0]   fold1;
	logic [phic_pkg::WORD_W:0]   fold2;
	logic                        out_valid_q;
	logic [phic_pkg::WORD_W-1:0] out_data_q;

	assign sum_next = running_sum_q + phic_pkg::SUM_W'(term);

	// fold twice: halves, then the carry of that add
	assign fold1 = {1'b0, sum_next[31:16]} + {1'b0, sum_next[15:0]};
	assign fold2 = fold1 + (phic_pkg::WORD_W+1)'(fold1[phic_pkg::WORD_W]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_sum_q <= '0;
		end else if (step.fire) begin
			running_sum_q <= step.last ? '0 : sum_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step.fire && step.last) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step.fire && step.last) begin
			out_data_q <= ~fold2[phic_pkg::WORD_W-1:0];
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [phic_pkg::PROTO_W-1:0] TCP_NUMBER = 8'd6;
	localparam logic [phic_pkg::PROTO_W-1:0] UDP_NUMBER = 8'd17;

	localparam bit ON  = 1'b1;
	localparam bit OFF = 1'b0;

	// run length guard and pressure settings
	localparam int unsigned CYCLE_LIMIT   = 1_000_000;
	localparam int unsigned HOLD_CYCLES   = 200;
	localparam int unsigned HOLD_SEGMENTS = 40;
	localparam int unsigned PHASE_ITEMS   = 200;
	localparam int unsigned TAIL_CYCLES   = 8;

	// one segment word with the side fields that only matter on the last one
	typedef struct {
		logic [phic_pkg::WORD_W-1:0]  data_word;
		logic                         is_last;
		logic                         odd_tail;
		logic                         use_pseudo;
		logic [phic_pkg::ADDR_W-1:0]  src_address;
		logic [phic_pkg::ADDR_W-1:0]  dst_address;
		logic [phic_pkg::WORD_W-1:0]  seg_length;
		logic [phic_pkg::PROTO_W-1:0] protocol;
	} seg_word_t;

	// directed stimulus row; a typed checksum overrides the predictor
	typedef struct {
		seg_word_t                   w;
		bit                          typed;
		logic [phic_pkg::WORD_W-1:0] csum;
	} stim_row_t;

	logic         clk;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	// s_tdata fields, low bit up: data_word, src_address, dst_address, seg_length, protocol
	logic [103:0] s_tdata = '0;
	logic         s_tlast = 1'b0;
	// s_tuser fields, low bit up: odd_tail, use_pseudo
	logic [1:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	// m_tdata fields, low bit up: checksum_value
	logic [15:0]  m_tdata;

	// predictor state and the checksums still owed by the block
	logic [phic_pkg::SUM_W-1:0]  segment_sum = '0;
	logic [phic_pkg::WORD_W-1:0] checksum_q[$];
	stim_row_t                   stim_table[$];

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	bit          hold_req = 1'b0;
	int unsigned hold_left = 0;
	int unsigned mismatches = 0;
	int unsigned cycle_count;

	pseudo_header_internet_checksum dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Advance the running sum by one accepted word; on the last word return 1
	// with the folded, complemented checksum and clear the sum.
	function automatic bit predict_checksum(input seg_word_t w,
		output logic [phic_pkg::WORD_W-1:0] csum);
		logic [phic_pkg::SUM_W-1:0] s;
		csum = '0;
		if (!w.is_last) begin
			segment_sum = segment_sum + phic_pkg::SUM_W'(w.data_word);
			return 1'b0;
		end
		s = segment_sum;
		if (w.use_pseudo) begin
			// odd tail pads the missing low byte with zero
			s = s + phic_pkg::SUM_W'(w.odd_tail ? (w.data_word & phic_pkg::ODD_MASK)
				: w.data_word);
			s = s + phic_pkg::SUM_W'(w.src_address[31:16])
				+ phic_pkg::SUM_W'(w.src_address[15:0]);
			s = s + phic_pkg::SUM_W'(w.dst_address[31:16])
				+ phic_pkg::SUM_W'(w.dst_address[15:0]);
			s = s + phic_pkg::SUM_W'(w.seg_length) + phic_pkg::SUM_W'(w.protocol);
		end else if (!w.odd_tail) begin
			s = s + phic_pkg::SUM_W'(w.data_word);
		end
		// plain mode drops an odd final word entirely
		s = (s >> 16) + (s & 32'h0000_FFFF);
		s = s + (s >> 16);
		csum = ~s[15:0];
		segment_sum = '0;
		return 1'b1;
	endfunction

	function automatic seg_word_t word_of(
		input logic [phic_pkg::WORD_W-1:0] data, input logic last, input logic odd,
		input logic pseudo,
		input logic [phic_pkg::ADDR_W-1:0] src, input logic [phic_pkg::ADDR_W-1:0] dst,
		input logic [phic_pkg::WORD_W-1:0] len, input logic [phic_pkg::PROTO_W-1:0] proto);
		seg_word_t w;
		w.data_word   = data;
		w.is_last     = last;
		w.odd_tail    = odd;
		w.use_pseudo  = pseudo;
		w.src_address = src;
		w.dst_address = dst;
		w.seg_length  = len;
		w.protocol    = proto;
		return w;
	endfunction

	// Random word: biased toward carry-heavy extremes and the two usual protocols.
	function automatic seg_word_t random_word(input logic last);
		seg_word_t   w;
		int unsigned pick;
		pick = $urandom_range(99);
		w.data_word   = (pick < 10) ? 16'hFFFF : (pick < 15) ? 16'h0000 : 16'($urandom);
		w.is_last     = last;
		w.odd_tail    = 1'($urandom_range(1));
		w.use_pseudo  = 1'($urandom_range(1));
		w.src_address = ($urandom_range(9) == 0) ? '1 : $urandom;
		w.dst_address = ($urandom_range(9) == 0) ? '1 : $urandom;
		w.seg_length  = ($urandom_range(15) == 0) ? '1 : 16'($urandom);
		pick = $urandom_range(9);
		w.protocol    = (pick < 4) ? TCP_NUMBER : (pick < 8) ? UDP_NUMBER : 8'($urandom);
		return w;
	endfunction

	task automatic report_mismatch(input string what, input logic [phic_pkg::WORD_W-1:0] want,
		input logic [phic_pkg::WORD_W-1:0] got);
		$display("mismatch at %0t: %s, expected %h, got %h", $realtime, what, want, got);
		mismatches++;
	endtask

	// Offer one item, idling first at the phase's rate, and hold it until it
	// is accepted. Queue the checksum it owes, if any, at the accepting edge.
	task automatic offer_word(input seg_word_t w, input bit typed,
		input logic [phic_pkg::WORD_W-1:0] typed_csum);
		logic [phic_pkg::WORD_W-1:0] csum;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {w.protocol, w.seg_length, w.dst_address, w.src_address, w.data_word};
		s_tlast  <= w.is_last;
		s_tuser  <= {w.use_pseudo, w.odd_tail};
		do @(posedge clk); while (!s_tready);
		if (predict_checksum(w, csum))
			checksum_q.push_back(typed ? typed_csum : csum);
	endtask

	task automatic send_segment(input int unsigned n_words);
		for (int unsigned i = 1; i <= n_words; i++)
			offer_word(random_word(i == n_words), 1'b0, '0);
	endtask

	// Drop valid and hold until the block owes nothing, then let it settle.
	task automatic drain;
		s_tvalid <= 1'b0;
		while (checksum_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// Receiver: check each accepted result, then pick the next ready. A hold
	// request holds ready low for a long stretch, counted here.
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				if (checksum_q.size() == 0)
					report_mismatch("result with none pending", '0, m_tdata);
				else if (m_tdata[15:0] !== checksum_q[0]) begin
					report_mismatch("checksum_value", checksum_q[0], m_tdata[15:0]);
					void'(checksum_q.pop_front());
				end else begin
					void'(checksum_q.pop_front());
				end
			end
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Guard against a hung handshake.
	initial begin
		for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
			@(posedge clk);
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		int unsigned sent;
		int unsigned n_words;
		int unsigned idle_plan[4];
		int unsigned stall_plan[4];

		idle_plan  = '{0, 87, 0, 38};
		stall_plan = '{0, 0, 87, 38};

		// Directed rows. Typed checksums: single zero word gives all ones, an
		// all-ones word gives zero, dropped or zero-padded tails give all ones.
		stim_table.push_back('{word_of(16'h0000, ON, OFF, OFF, '0, '0, '0, '0), ON, 16'hFFFF});
		stim_table.push_back('{word_of(16'hFFFF, ON, OFF, OFF, '0, '0, '0, '0), ON, 16'h0000});
		stim_table.push_back('{word_of(16'hABCD, ON, ON, OFF, '1, '1, '1, '1), ON, 16'hFFFF});
		stim_table.push_back('{word_of(16'h0000, ON, OFF, ON, '0, '0, '0, '0), ON, 16'hFFFF});
		stim_table.push_back('{word_of(16'h00FF, ON, ON, ON, '0, '0, '0, '0), ON, 16'hFFFF});
		// pseudo header with every field at its maximum
		stim_table.push_back('{word_of(16'hFFFF, ON, OFF, ON, '1, '1, '1, '1), OFF, '0});
		// textbook IPv4 header; side flags on inner words must be ignored
		stim_table.push_back('{word_of(16'h4500, OFF, ON, ON, '1, '1, '1, '1), OFF, '0});
		stim_table.push_back('{word_of(16'h0073, OFF, OFF, ON, '0, '0, '0, '0), OFF, '0});
		stim_table.push_back('{word_of(16'h0000, OFF, ON, OFF, '0, '0, '0, '0), OFF, '0});
		stim_table.push_back('{word_of(16'h4000, OFF, OFF, OFF, '0, '0, '0, '0), OFF, '0});
		stim_table.push_back('{word_of(16'h4011, OFF, OFF, OFF, '0, '0, '0, '0), OFF, '0});
		stim_table.push_back('{word_of(16'h0000, OFF, OFF, OFF, '0, '0, '0, '0), OFF, '0});
		stim_table.push_back('{word_of(16'hC0A8, OFF, OFF, OFF, '0, '0, '0, '0), OFF, '0});
		stim_table.push_back('{word_of(16'h0001, OFF, OFF, OFF, '0, '0, '0, '0), OFF, '0});
		stim_table.push_back('{word_of(16'hC0A8, OFF, OFF, OFF, '0, '0, '0, '0), OFF, '0});
		stim_table.push_back('{word_of(16'h00C7, ON, OFF, OFF, '0, '0, '0, '0), OFF, '0});
		// TCP with an odd tail: low byte of the last word padded with zero
		stim_table.push_back('{word_of(16'h1234, OFF, ON, ON, '1, '0, '1, UDP_NUMBER),
			OFF, '0});
		stim_table.push_back('{word_of(16'h56FF, ON, ON, ON, 32'hC0A8_0001, 32'hC0A8_00C7,
			16'd3, TCP_NUMBER), OFF, '0});
		// UDP, carry-heavy
		stim_table.push_back('{word_of(16'hFFFF, OFF, OFF, OFF, '0, '0, '0, '0), OFF, '0});
		stim_table.push_back('{word_of(16'hFFFF, ON, OFF, ON, '1, '0, '1, UDP_NUMBER),
			OFF, '0});
		// protocol other than TCP or UDP is added as given
		stim_table.push_back('{word_of(16'h8001, ON, OFF, ON, 32'h1234_5678, 32'h9ABC_DEF0,
			16'h0040, 8'h5A), OFF, '0});
		// plain mode odd tail after a real word: tail dropped, sum kept
		stim_table.push_back('{word_of(16'h8000, OFF, OFF, OFF, '0, '0, '0, '0), OFF, '0});
		stim_table.push_back('{word_of(16'h7FFF, ON, ON, OFF, '1, '1, '1, '1), OFF, '0});

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_table[i])
			offer_word(stim_table[i].w, stim_table[i].typed, stim_table[i].csum);

		// Hold the receiver off while single-word segments keep coming, so the
		// result slot fills and the input stalls; then pause until all arrive.
		hold_req = 1'b1;
		for (int unsigned i = 0; i < HOLD_SEGMENTS; i++)
			send_segment(1);
		drain();

		// Random phases: mostly short segments, a few long ones.
		for (int p = 0; p < 4; p++) begin
			send_idle_pct  = idle_plan[p];
			recv_stall_pct = stall_plan[p];
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				n_words = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
				send_segment(n_words);
				sent += n_words;
			end
			drain();
		end

		if (mismatches == 0 && checksum_q.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
